// File: hdl/ngp_pkg.sv
// ----------------------------------------------------------------------------
// ngp_pkg
// Shared types, command codes and the sentence grammar tables of the GGA parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ngp_pkg;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_EMIT  = 2'd2;

    localparam logic [1:0] KIND_LIT  = 2'd0;
    localparam logic [1:0] KIND_TIME = 2'd1;
    localparam logic [1:0] KIND_NUM  = 2'd2;
    localparam logic [1:0] KIND_CHR  = 2'd3;

    localparam logic [4:0] STEP_DONE = 5'd22;
    localparam int         NUM_SLOTS = 10;

    localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_COMMA   = 8'h2C;
    localparam logic [7:0] CHAR_POINT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic       parse_ok;
        logic [6:0] lat_degrees;
        logic [6:0] lat_minutes;
        logic [6:0] lat_minute_frac_hi;
        logic [6:0] lat_minute_frac_lo;
        logic [7:0] lat_hemisphere;
        logic [9:0] lon_degrees;
        logic [6:0] lon_minutes;
        logic [6:0] lon_minute_frac_hi;
        logic [6:0] lon_minute_frac_lo;
        logic [7:0] lon_hemisphere;
    } res_t;

    function automatic logic [1:0] step_kind(input logic [4:0] step);
        logic [1:0] k;
        case (step)
            5'd6:                              k = KIND_TIME;
            5'd7, 5'd8, 5'd10, 5'd11,
            5'd15, 5'd16, 5'd18, 5'd19:        k = KIND_NUM;
            5'd13, 5'd21:                      k = KIND_CHR;
            default:                           k = KIND_LIT;
        endcase
        return k;
    endfunction

    function automatic logic [7:0] step_char(input logic [4:0] step);
        logic [7:0] c;
        case (step)
            5'd0, 5'd2, 5'd3: c = 8'h47;
            5'd1:             c = 8'h50;
            5'd4:             c = 8'h41;
            5'd9, 5'd17:      c = CHAR_POINT;
            default:          c = CHAR_COMMA;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] step_slot(input logic [4:0] step);
        logic [3:0] s;
        case (step)
            5'd8:    s = 4'd1;
            5'd10:   s = 4'd2;
            5'd11:   s = 4'd3;
            5'd13:   s = 4'd4;
            5'd15:   s = 4'd5;
            5'd16:   s = 4'd6;
            5'd18:   s = 4'd7;
            5'd19:   s = 4'd8;
            5'd21:   s = 4'd9;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] step_max(input logic [4:0] step);
        logic [2:0] m;
        case (step)
            5'd15:   m = 3'd3;
            default: m = 3'd2;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ngp_front.sv
// ----------------------------------------------------------------------------
// ngp_front
// Sentence framing: finds the start character, counts the body against the
// length limit and turns '$', newline and body bytes within it into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ngp_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rx_valid,
    input  wire logic [7:0]  rx_byte,
    output logic             rx_stall,
    input  wire logic [7:0]  max_len,
    input  wire logic        q_full,
    output logic             push,
    output ngp_pkg::cmd_t    cmd
);
    import ngp_pkg::*;

    logic       frame_reg;
    logic       frame_next;
    logic [7:0] len_reg;
    logic [7:0] len_next;
    logic [8:0] len_inc;
    logic       accept;

    assign rx_stall = q_full;
    assign accept   = rx_valid && !q_full;
    assign len_inc  = {1'b0, len_reg} + 9'd1;

    always_comb
    begin
        frame_next = frame_reg;
        len_next   = len_reg;
        push       = 1'b0;
        cmd.kind   = CMD_BYTE;
        cmd.data   = rx_byte;
        if (accept)
        begin
            if (rx_byte == CHAR_DOLLAR)
            begin
                push       = 1'b1;
                cmd.kind   = CMD_START;
                frame_next = (max_len != 8'd0);
                len_next   = 8'd0;
            end
            else if (frame_reg)
            begin
                if (rx_byte == CHAR_NEWLINE)
                begin
                    push       = 1'b1;
                    cmd.kind   = CMD_EMIT;
                    frame_next = 1'b0;
                end
                else if (len_inc >= {1'b0, max_len})
                begin
                    frame_next = 1'b0;
                    len_next   = 8'd0;
                end
                else
                begin
                    push     = 1'b1;
                    len_next = len_inc[7:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= 1'b0;
            len_reg   <= 8'd0;
        end
        else
        begin
            frame_reg <= frame_next;
            len_reg   <= len_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ngp_queue.sv
// ----------------------------------------------------------------------------
// ngp_queue
// Small command queue between the framing front and the parsing back.
// ----------------------------------------------------------------------------
`default_nettype none

module ngp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire ngp_pkg::cmd_t push_cmd,
    output logic             full,
    output logic             head_valid,
    output ngp_pkg::cmd_t    head_cmd,
    input  wire logic        pop
);
    import ngp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/ngp_back.sv
// ----------------------------------------------------------------------------
// ngp_back
// GGA body matcher: walks the grammar one byte per command, accumulates the
// ten position values and holds each finished result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ngp_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire ngp_pkg::cmd_t head_cmd,
    output logic             pop,
    output logic             res_valid,
    input  wire logic        res_stall,
    output ngp_pkg::res_t    res
);
    import ngp_pkg::*;

    logic [4:0] step_reg;
    logic [4:0] step_next;
    logic [1:0] dc_reg;
    logic [1:0] dc_next;
    logic       failed_reg;
    logic       failed_next;
    logic [9:0] held_reg [NUM_SLOTS];
    logic       out_valid_reg;
    res_t       res_reg;
    res_t       res_next;

    logic [7:0]  c;
    logic        is_digit;
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [4:0]  step2;
    logic [9:0]  base;
    logic [13:0] acc;
    logic [2:0]  dc_inc;
    logic        wr_en;
    logic [3:0]  wr_slot;
    logic [9:0]  wr_val;
    logic        emit_ok;
    logic        do_pop;

    assign c        = head_cmd.data;
    assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    assign kind     = step_kind(step_reg);
    assign slot     = step_slot(step_reg);
    assign step2    = step_reg + 5'd1;
    assign base     = (dc_reg == 2'd0) ? 10'd0 : held_reg[slot];
    assign acc      = 14'(base) * 14'd10 + 14'(c - CHAR_ZERO);
    assign dc_inc   = {1'b0, dc_reg} + 3'd1;
    assign emit_ok  = !failed_reg && (step_reg == STEP_DONE);

    assign pop       = head_valid && !((head_cmd.kind == CMD_EMIT) && out_valid_reg && res_stall);
    assign do_pop    = pop;
    assign res_valid = out_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        step_next   = step_reg;
        dc_next     = dc_reg;
        failed_next = failed_reg;
        wr_en       = 1'b0;
        wr_slot     = slot;
        wr_val      = acc[9:0];
        if (c == 8'd0)
        begin
            if (step_reg != STEP_DONE)
            begin
                failed_next = 1'b1;
            end
        end
        else if (!failed_reg && (step_reg < STEP_DONE))
        begin
            case (kind)
                KIND_LIT:
                begin
                    if (c == step_char(step_reg))
                    begin
                        step_next = step2;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                KIND_TIME:
                begin
                    if (is_digit)
                    begin
                        dc_next = dc_reg | 2'b01;
                    end
                    else if ((c == CHAR_POINT) && !dc_reg[1])
                    begin
                        dc_next = dc_reg | 2'b10;
                    end
                    else if ((c == CHAR_COMMA) && dc_reg[0])
                    begin
                        step_next = step2;
                        dc_next   = 2'd0;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                KIND_CHR:
                begin
                    wr_en     = 1'b1;
                    wr_val    = {2'b00, c};
                    step_next = step2;
                end
                default:
                begin
                    if (is_digit)
                    begin
                        wr_en = 1'b1;
                        if (dc_inc >= step_max(step_reg))
                        begin
                            step_next = step2;
                            dc_next   = 2'd0;
                        end
                        else
                        begin
                            dc_next = dc_inc[1:0];
                        end
                    end
                    else if (dc_reg == 2'd0)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        // The field ended early; the same byte is matched
                        // against the element that follows it.
                        dc_next = 2'd0;
                        case (step_kind(step2))
                            KIND_LIT:
                            begin
                                if (c == step_char(step2))
                                begin
                                    step_next = step2 + 5'd1;
                                end
                                else
                                begin
                                    step_next   = step2;
                                    failed_next = 1'b1;
                                end
                            end
                            KIND_CHR:
                            begin
                                wr_en     = 1'b1;
                                wr_slot   = step_slot(step2);
                                wr_val    = {2'b00, c};
                                step_next = step2 + 5'd1;
                            end
                            default:
                            begin
                                step_next   = step2;
                                failed_next = 1'b1;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        res_next                    = '0;
        res_next.parse_ok           = emit_ok;
        if (emit_ok)
        begin
            res_next.lat_degrees        = held_reg[0][6:0];
            res_next.lat_minutes        = held_reg[1][6:0];
            res_next.lat_minute_frac_hi = held_reg[2][6:0];
            res_next.lat_minute_frac_lo = held_reg[3][6:0];
            res_next.lat_hemisphere     = held_reg[4][7:0];
            res_next.lon_degrees        = held_reg[5];
            res_next.lon_minutes        = held_reg[6][6:0];
            res_next.lon_minute_frac_hi = held_reg[7][6:0];
            res_next.lon_minute_frac_lo = held_reg[8][6:0];
            res_next.lon_hemisphere     = held_reg[9][7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && (head_cmd.kind == CMD_EMIT))
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 5'd0;
            dc_reg        <= 2'd0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                held_reg[i] <= 10'd0;
            end
        end
        else
        begin
            if (out_valid_reg && !res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (do_pop)
            begin
                case (head_cmd.kind)
                    CMD_START:
                    begin
                        step_reg   <= 5'd0;
                        dc_reg     <= 2'd0;
                        failed_reg <= 1'b0;
                        for (int i = 0; i < NUM_SLOTS; i++)
                        begin
                            held_reg[i] <= 10'd0;
                        end
                    end
                    CMD_BYTE:
                    begin
                        step_reg   <= step_next;
                        dc_reg     <= dc_next;
                        failed_reg <= failed_next;
                        if (wr_en)
                        begin
                            held_reg[wr_slot] <= wr_val;
                        end
                    end
                    CMD_EMIT:
                    begin
                        out_valid_reg <= 1'b1;
                    end
                    default:
                    begin
                        out_valid_reg <= out_valid_reg;
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// File: hdl/nmea_gga_position_parser.sv
// ----------------------------------------------------------------------------
// nmea_gga_position_parser
// Streaming GGA sentence parser with a register port for the length limit.
// ----------------------------------------------------------------------------
// Usage: serial bytes enter on rx_byte with rx_valid; a transaction completes
// at a clock edge where rx_valid is high and rx_stall is low. Bytes before
// '$' are ignored, '$' opens a sentence and a newline closes it with one
// result transaction on res_valid/res_stall carrying parse_ok and the ten
// position values (zeros when parse_ok is low). Bodies that reach max_len
// bytes are dropped without a result.
// Throughput is one byte per cycle while rx_stall is low. An accepted
// newline enters the command queue; the matcher then pops it and loads its
// output register, which holds the result, unless an earlier result is
// still stalled.
// While the receiver stalls a result, the matcher keeps consuming body bytes
// and stops only at the next newline; the queue then fills and rx_stall
// rises once QUEUE_DEPTH commands are waiting.
// Reset clears the framing, the queue, the matcher and the output valid, and
// sets max_len to 82. max_len is written over the register port at address 0.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_gga_position_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             res_valid,
    input  wire logic        res_stall,
    output logic             parse_ok,
    output logic      [6:0]  lat_degrees,
    output logic      [6:0]  lat_minutes,
    output logic      [6:0]  lat_minute_frac_hi,
    output logic      [6:0]  lat_minute_frac_lo,
    output logic      [7:0]  lat_hemisphere,
    output logic      [9:0]  lon_degrees,
    output logic      [6:0]  lon_minutes,
    output logic      [6:0]  lon_minute_frac_hi,
    output logic      [6:0]  lon_minute_frac_lo,
    output logic      [7:0]  lon_hemisphere
);
    import ngp_pkg::*;

    localparam logic [0:0] ADDR_MAX_LEN = 1'b0;

    logic [7:0] max_len_reg;
    logic       q_full;
    logic       q_push;
    cmd_t       q_push_cmd;
    logic       q_head_valid;
    cmd_t       q_head_cmd;
    logic       q_pop;
    res_t       res;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MAX_LEN) ? {24'd0, max_len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= 8'd82;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_MAX_LEN))
        begin
            max_len_reg <= pwdata[7:0];
        end
    end

    ngp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_byte  (rx_byte),
        .rx_stall (rx_stall),
        .max_len  (max_len_reg),
        .q_full   (q_full),
        .push     (q_push),
        .cmd      (q_push_cmd)
    );

    ngp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop)
    );

    ngp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

    assign parse_ok           = res.parse_ok;
    assign lat_degrees        = res.lat_degrees;
    assign lat_minutes        = res.lat_minutes;
    assign lat_minute_frac_hi = res.lat_minute_frac_hi;
    assign lat_minute_frac_lo = res.lat_minute_frac_lo;
    assign lat_hemisphere     = res.lat_hemisphere;
    assign lon_degrees        = res.lon_degrees;
    assign lon_minutes        = res.lon_minutes;
    assign lon_minute_frac_hi = res.lon_minute_frac_hi;
    assign lon_minute_frac_lo = res.lon_minute_frac_lo;
    assign lon_hemisphere     = res.lon_hemisphere;

endmodule

`default_nettype wire

// File: hdl/ngp_checker.sv
// ----------------------------------------------------------------------------
// ngp_checker
// Port-level checks on the result channel and register port of the GGA parser.
// ----------------------------------------------------------------------------
`default_nettype none

module ngp_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pready,
    input  wire logic        res_valid,
    input  wire logic        res_stall,
    input  wire logic        parse_ok,
    input  wire logic [6:0]  lat_degrees,
    input  wire logic [6:0]  lat_minutes,
    input  wire logic [6:0]  lat_minute_frac_hi,
    input  wire logic [6:0]  lat_minute_frac_lo,
    input  wire logic [7:0]  lat_hemisphere,
    input  wire logic [9:0]  lon_degrees,
    input  wire logic [6:0]  lon_minutes,
    input  wire logic [6:0]  lon_minute_frac_hi,
    input  wire logic [6:0]  lon_minute_frac_lo,
    input  wire logic [7:0]  lon_hemisphere
);

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(parse_ok)
            && $stable(lat_degrees) && $stable(lon_degrees)
            && $stable(lat_hemisphere) && $stable(lon_hemisphere))
    else $error("Stalled result transaction changed or dropped.");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !parse_ok |-> (lat_degrees == 7'd0) && (lat_minutes == 7'd0)
            && (lat_minute_frac_hi == 7'd0) && (lat_minute_frac_lo == 7'd0)
            && (lat_hemisphere == 8'd0) && (lon_degrees == 10'd0)
            && (lon_minutes == 7'd0) && (lon_minute_frac_hi == 7'd0)
            && (lon_minute_frac_lo == 7'd0) && (lon_hemisphere == 8'd0))
    else $error("Failed parse carries nonzero position values.");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && parse_ok |-> (lat_degrees <= 7'd99) && (lat_minutes <= 7'd99)
            && (lat_minute_frac_hi <= 7'd99) && (lat_minute_frac_lo <= 7'd99)
            && (lon_degrees <= 10'd999) && (lon_minutes <= 7'd99)
            && (lon_minute_frac_hi <= 7'd99) && (lon_minute_frac_lo <= 7'd99))
    else $error("Parsed position value exceeds its digit count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        pready)
    else $error("Register port wait state inserted.");

endmodule

bind nmea_gga_position_parser ngp_checker u_ngp_checker (.*);

`default_nettype wire

// File: tb/tb_nmea_gga_position_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmea_gga_position_parser
// Self-checking regression for the streaming GGA position parser.
// Serial bytes are queued by a stimulus process and fed to the block by a
// clocked driver. Each accepted byte also advances a local sentence matcher,
// which queues the position fix that a newline should produce. A clocked
// monitor compares every fix transaction field by field against that queue.
// The length limit is rewritten between phases, and both sides of the stream
// stall at random except in the last phase, with one long receiver hold-off.
// ----------------------------------------------------------------------------

module tb_nmea_gga_position_parser;

    import ngp_pkg::*;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         GAP_PERCENT  = 16;
    localparam int         MAX_PRINTS   = 50;
    localparam logic [0:0] ADDR_MAX_LEN = 1'b0;
    localparam logic [7:0] PAT_TIME     = "t";
    localparam logic [7:0] PAT_HEMI     = "h";
    localparam int         PAT_LEN      = 22;
    localparam logic [8*PAT_LEN-1:0] GGA_PATTERN = "GPGGA,t22.22,h,32.22,h";

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [0:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        rx_valid = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic        parse_ok;
    logic [6:0]  lat_degrees;
    logic [6:0]  lat_minutes;
    logic [6:0]  lat_minute_frac_hi;
    logic [6:0]  lat_minute_frac_lo;
    logic [7:0]  lat_hemisphere;
    logic [9:0]  lon_degrees;
    logic [6:0]  lon_minutes;
    logic [6:0]  lon_minute_frac_hi;
    logic [6:0]  lon_minute_frac_lo;
    logic [7:0]  lon_hemisphere;

    logic [7:0] serial_backlog[$];
    res_t       expected_fixes[$];
    int         bytes_pushed = 0;
    int         bytes_accepted = 0;
    int         error_count = 0;
    int         cycle_count = 0;
    int         hold_left = 0;
    int         hold_at = 32'h7fff_ffff;
    bit         hold_done = 1'b0;
    bit         steady_flow = 1'b0;

    logic [7:0] limit_cfg = 8'd82;
    bit         in_sentence = 1'b0;
    int         body_len = 0;
    int         gga_step = 0;
    int         gga_digits = 0;
    bit         time_digit = 1'b0;
    bit         time_point = 1'b0;
    bit         gga_failed = 1'b0;
    logic [9:0] gga_values[NUM_SLOTS];

    nmea_gga_position_parser u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .rx_valid           (rx_valid),
        .rx_stall           (rx_stall),
        .rx_byte            (rx_byte),
        .res_valid          (res_valid),
        .res_stall          (res_stall),
        .parse_ok           (parse_ok),
        .lat_degrees        (lat_degrees),
        .lat_minutes        (lat_minutes),
        .lat_minute_frac_hi (lat_minute_frac_hi),
        .lat_minute_frac_lo (lat_minute_frac_lo),
        .lat_hemisphere     (lat_hemisphere),
        .lon_degrees        (lon_degrees),
        .lon_minutes        (lon_minutes),
        .lon_minute_frac_hi (lon_minute_frac_hi),
        .lon_minute_frac_lo (lon_minute_frac_lo),
        .lon_hemisphere     (lon_hemisphere)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sentence matcher
    // ------------------------------------------------------------------

    function automatic logic [7:0] pattern_at(input int idx);
        return GGA_PATTERN[8*(PAT_LEN-1-idx) +: 8];
    endfunction

    function automatic logic [1:0] elem_kind(input logic [7:0] p);
        if (p == PAT_TIME)
            return KIND_TIME;
        if (p == PAT_HEMI)
            return KIND_CHR;
        if (p >= CHAR_ZERO && p <= CHAR_NINE)
            return KIND_NUM;
        return KIND_LIT;
    endfunction

    function automatic int slot_of(input int idx);
        int n = 0;
        for (int j = 0; j < idx; j++)
        begin
            if (elem_kind(pattern_at(j)) == KIND_NUM || elem_kind(pattern_at(j)) == KIND_CHR)
                n++;
        end
        return n;
    endfunction

    function automatic void open_sentence();
        body_len = 0;
        gga_step = 0;
        gga_digits = 0;
        time_digit = 1'b0;
        time_point = 1'b0;
        gga_failed = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
            gga_values[i] = '0;
    endfunction

    // Returns 1 when a number field ended early and the byte must be matched again.
    function automatic bit match_gga_char(input logic [7:0] c);
        logic [7:0] p;
        int         slot;
        int         width;
        int         acc;
        bit         is_digit;
        if (gga_failed || gga_step >= int'(STEP_DONE))
            return 1'b0;
        p = pattern_at(gga_step);
        slot = slot_of(gga_step);
        is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        case (elem_kind(p))
            KIND_LIT:
            begin
                if (c == p)
                    gga_step++;
                else
                    gga_failed = 1'b1;
            end
            KIND_TIME:
            begin
                if (is_digit)
                    time_digit = 1'b1;
                else if (c == CHAR_POINT && !time_point)
                    time_point = 1'b1;
                else if (c == CHAR_COMMA && time_digit)
                    gga_step++;
                else
                    gga_failed = 1'b1;
            end
            KIND_CHR:
            begin
                gga_values[slot] = {2'b00, c};
                gga_step++;
            end
            default:
            begin
                width = int'(p - CHAR_ZERO);
                if (is_digit)
                begin
                    acc = (gga_digits == 0) ? 0 : int'(gga_values[slot]);
                    acc = acc * 10 + int'(c - CHAR_ZERO);
                    gga_values[slot] = acc[9:0];
                    gga_digits++;
                    if (gga_digits >= width)
                    begin
                        gga_step++;
                        gga_digits = 0;
                    end
                end
                else if (gga_digits == 0)
                begin
                    gga_failed = 1'b1;
                end
                else
                begin
                    gga_step++;
                    gga_digits = 0;
                    return 1'b1;
                end
            end
        endcase
        return 1'b0;
    endfunction

    function automatic void predict_gga_byte(input logic [7:0] c);
        res_t fix;
        if (c == CHAR_DOLLAR)
        begin
            open_sentence();
            in_sentence = (limit_cfg != 8'd0);
            return;
        end
        if (!in_sentence)
            return;
        if (c == CHAR_NEWLINE)
        begin
            fix = '0;
            if (!gga_failed && gga_step == int'(STEP_DONE))
            begin
                fix.parse_ok           = 1'b1;
                fix.lat_degrees        = gga_values[0][6:0];
                fix.lat_minutes        = gga_values[1][6:0];
                fix.lat_minute_frac_hi = gga_values[2][6:0];
                fix.lat_minute_frac_lo = gga_values[3][6:0];
                fix.lat_hemisphere     = gga_values[4][7:0];
                fix.lon_degrees        = gga_values[5];
                fix.lon_minutes        = gga_values[6][6:0];
                fix.lon_minute_frac_hi = gga_values[7][6:0];
                fix.lon_minute_frac_lo = gga_values[8][6:0];
                fix.lon_hemisphere     = gga_values[9][7:0];
            end
            expected_fixes.push_back(fix);
            in_sentence = 1'b0;
            return;
        end
        body_len++;
        if (c == 8'd0)
        begin
            if (gga_step != int'(STEP_DONE))
                gga_failed = 1'b1;
        end
        else if (match_gga_char(c))
        begin
            void'(match_gga_char(c));
        end
        if (body_len >= int'(limit_cfg))
        begin
            in_sentence = 1'b0;
            open_sentence();
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void report_error(input string msg);
        if (error_count < MAX_PRINTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endfunction

    function automatic void check_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("%s is %0d, expected %0d", name, got, want));
    endfunction

    function automatic void check_fix();
        res_t want;
        if (expected_fixes.size() == 0)
        begin
            report_error("fix transaction with no sentence pending");
            return;
        end
        want = expected_fixes.pop_front();
        check_field("parse_ok", parse_ok, want.parse_ok);
        check_field("lat_degrees", lat_degrees, want.lat_degrees);
        check_field("lat_minutes", lat_minutes, want.lat_minutes);
        check_field("lat_minute_frac_hi", lat_minute_frac_hi, want.lat_minute_frac_hi);
        check_field("lat_minute_frac_lo", lat_minute_frac_lo, want.lat_minute_frac_lo);
        check_field("lat_hemisphere", lat_hemisphere, want.lat_hemisphere);
        check_field("lon_degrees", lon_degrees, want.lon_degrees);
        check_field("lon_minutes", lon_minutes, want.lon_minutes);
        check_field("lon_minute_frac_hi", lon_minute_frac_hi, want.lon_minute_frac_hi);
        check_field("lon_minute_frac_lo", lon_minute_frac_lo, want.lon_minute_frac_lo);
        check_field("lon_hemisphere", lon_hemisphere, want.lon_hemisphere);
    endfunction

    // ------------------------------------------------------------------
    // Driver, monitor, hold-off and watchdog
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_valid && !rx_stall)
            begin
                predict_gga_byte(rx_byte);
                bytes_accepted++;
            end
            if (!rx_valid || !rx_stall)
            begin
                if (serial_backlog.size() != 0
                    && (steady_flow || $urandom_range(99) >= GAP_PERCENT))
                begin
                    rx_valid <= 1'b1;
                    rx_byte  <= serial_backlog.pop_front();
                end
                else
                begin
                    rx_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                check_fix();
            res_stall <= (hold_left != 0)
                         || (!steady_flow && $urandom_range(99) < GAP_PERCENT);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && bytes_accepted >= hold_at)
            begin
                hold_left <= HOLD_CYCLES;
                hold_done <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("nmea_gga_position_parser regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    function automatic logic [7:0] rand_char(input int lo, input int hi);
        int v;
        v = $urandom_range(hi, lo);
        return v[7:0];
    endfunction

    function automatic void push_byte(input logic [7:0] b);
        serial_backlog.push_back(b);
        bytes_pushed++;
    endfunction

    function automatic void push_text(input string t);
        for (int i = 0; i < t.len(); i++)
            push_byte(t[i]);
    endfunction

    function automatic void push_digits(input int n);
        for (int i = 0; i < n; i++)
            push_byte(rand_char(CHAR_ZERO, CHAR_NINE));
    endfunction

    function automatic void push_sample_coords();
        push_text(",4807.038,N,01131.000,E");
    endfunction

    function automatic void push_time_field();
        case ($urandom_range(19))
            0: push_text(".");
            1: push_text("1.2.3");
            2: push_text("+12");
            3: push_text(" 12");
            4: push_text("1e3");
            5: ;
            6: push_text(".5");
            default:
            begin
                push_digits($urandom_range(6, 1));
                if ($urandom_range(1) != 0)
                begin
                    push_text(".");
                    push_digits($urandom_range(3));
                end
            end
        endcase
        push_text(",");
    endfunction

    function automatic void push_coord(input int deg_max, input logic [7:0] h_a,
                                       input logic [7:0] h_b);
        if ($urandom_range(7) == 0)
            push_digits($urandom_range(deg_max + 3));
        else
            push_digits(deg_max + $urandom_range(2, 1));
        if ($urandom_range(15) != 0)
            push_text(".");
        if ($urandom_range(7) == 0)
            push_digits($urandom_range(5));
        else
            push_digits($urandom_range(4, 3));
        push_text(",");
        if ($urandom_range(7) == 0)
            push_byte(rand_char(0, 255));
        else
            push_byte(($urandom_range(1) != 0) ? h_a : h_b);
    endfunction

    function automatic void push_gga_sentence();
        int start;
        int n;
        start = serial_backlog.size();
        push_text("$GPGGA,");
        push_time_field();
        push_coord(2, "N", "S");
        push_text(",");
        push_coord(3, "E", "W");
        case ($urandom_range(9))
            4, 5, 6, 7: push_text(",1,08,0.9,545.4,M,46.9,M,,*47");
            8:
            begin
                n = $urandom_range(20);
                for (int i = 0; i < n; i++)
                    push_byte(rand_char(8'h20, 8'h7E));
            end
            9:
            begin
                n = $urandom_range(60, 20);
                for (int i = 0; i < n; i++)
                    push_byte(rand_char(8'h41, 8'h7E));
            end
            default: ;
        endcase
        if ($urandom_range(19) != 0)
            push_byte(CHAR_NEWLINE);
        if ($urandom_range(9) == 0)
            serial_backlog[$urandom_range(serial_backlog.size() - 1, start + 1)] =
                ($urandom_range(3) == 0) ? 8'd0 : rand_char(0, 255);
    endfunction

    function automatic void push_short_sentence();
        int n;
        n = $urandom_range(3);
        push_byte(CHAR_DOLLAR);
        for (int i = 0; i < n; i++)
            push_byte(rand_char(0, 255));
        push_byte(CHAR_NEWLINE);
    endfunction

    function automatic void push_traffic(input int budget, input int short_percent);
        int stop;
        int r;
        stop = bytes_pushed + budget;
        while (bytes_pushed < stop)
        begin
            r = $urandom_range(99);
            if (r < short_percent)
            begin
                push_short_sentence();
            end
            else if (r < short_percent + 10)
            begin
                for (int i = $urandom_range(6, 1); i > 0; i--)
                    push_byte(rand_char(0, 255));
            end
            else
            begin
                push_gga_sentence();
            end
        end
    endfunction

    task automatic wait_drained();
        while (bytes_accepted != bytes_pushed || expected_fixes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [7:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_LEN;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        limit_cfg = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        push_text("xyz\n");
        push_text("$GPGGA,123519.00,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\n");
        push_text("$GPGGA,999999,9999.9999,");
        push_byte(8'hFF);
        push_text(",99999.9999,");
        push_byte(8'hFF);
        push_text("\n$GPGGA,0,000.000,");
        push_byte(8'h01);
        push_text(",0000.000,");
        push_byte(8'h01);
        push_text("\n$GPGGA,.5,100.100,S,1000.100,W\n");
        push_text("$GPGGA,1,1.1234,N,001.1,E\n");
        push_text("$GPGGA,1.2.3");
        push_sample_coords();
        push_text("\n$GPGGA,+12");
        push_sample_coords();
        push_text("\n$GPGGA,1e3");
        push_sample_coords();
        push_text("\n$GPGGA, 12");
        push_sample_coords();
        push_text("\n$GPGGA,.");
        push_sample_coords();
        push_text("\n$GPGGA,");
        push_sample_coords();
        push_text("\n$GPGGB,1");
        push_sample_coords();
        push_text("\n$GPRMC,1");
        push_sample_coords();
        push_text("\n$GPGGA,12$GPGGA,1");
        push_sample_coords();
        push_text("\n$\n$GPGGA,1,48");
        push_byte(8'd0);
        push_text("07.038,N,01131.000,E\n$GPGGA,1");
        push_sample_coords();
        push_byte(8'd0);
        push_text("\n$GPGGA,1");
        push_sample_coords();
        push_text("$GPGGA,1,4807.038,,,01131.000,,\n$GPGGA,1");
        push_sample_coords();
        push_text(",xxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxxx\n");
        wait_drained();

        write_max_len(8'd255);
        hold_at = bytes_pushed + 80;
        push_traffic(150, 8);
        push_text("$GPGGA,1");
        push_sample_coords();
        for (int i = $urandom_range(260, 200); i > 0; i--)
            push_byte(rand_char(8'h41, 8'h7E));
        push_byte(CHAR_NEWLINE);
        push_text("$GPGGA,12");
        wait_drained();

        // The open sentence continues under the shorter limit and is dropped.
        write_max_len(8'd30);
        push_sample_coords();
        push_byte(CHAR_NEWLINE);
        push_traffic(100, 8);
        wait_drained();

        write_max_len(8'd2);
        push_traffic(60, 85);
        wait_drained();

        write_max_len(8'd0);
        push_traffic(40, 50);
        wait_drained();

        write_max_len(8'd82);
        steady_flow = 1'b1;
        push_traffic(120, 8);
        wait_drained();

        if (error_count == 0)
            $display("nmea_gga_position_parser regression: pass");
        else
            $display("nmea_gga_position_parser regression: fail");
        $finish;
    end

endmodule
